### rtl/max_heap_priority_queue_unit_assert.svh
// Assertion macros for the max-heap priority queue unit.
// Included by the top level; depends on nothing else.
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MHPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MHPQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define MHPQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/mhpq_pkg.sv
// Shared types, constants and helpers for the max-heap priority queue unit.
// Depends on nothing; used by mhpq_cell and max_heap_priority_queue_unit.
`default_nettype none

package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int COUNT_W  = 7;
	localparam int LEVELS   = $clog2(CAPACITY) + 1;
	localparam int POS_W    = LEVELS - 1;
	localparam int ROW_W    = POS_W - 1;
	localparam int LVL_W    = $clog2(LEVELS);
	localparam int IDX_W    = COUNT_W + 1;
	localparam int PRIO_W   = 16;
	localparam int TAG_W    = 16;

	localparam logic signed [PRIO_W-1:0] EMPTY_PRIO = -16'sd1;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_RUN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]         tag;
	} entry_t;

	// The two siblings that share one storage row of a level.
	typedef struct packed {
		entry_t left;
		entry_t right;
	} pair_t;

	// The entry being sifted, with its direction and its place in the level.
	typedef struct packed {
		logic             valid;
		logic             up;
		logic [POS_W-1:0] pos;
		entry_t           ent;
	} token_t;

	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
	} rd_req_t;

	// Index of the highest set bit, which is the heap level of a 1-based slot.
	function automatic logic [LVL_W-1:0] msb_of(input logic [COUNT_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int i = 0; i < COUNT_W; i++) begin
			if (v[i]) begin
				r = LVL_W'(i);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/mhpq_cell.sv
// One heap level: its slots in flip-flops, plus the compare-and-move step
// for a sift token at this level. Depends on mhpq_pkg.
`default_nettype none

module mhpq_cell #(
	parameter int LEVEL = 0
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire mhpq_pkg::token_t          inj,
	input  wire mhpq_pkg::token_t          down_in,
	input  wire mhpq_pkg::token_t          up_in,
	input  wire [mhpq_pkg::COUNT_W-1:0]    count,
	input  wire [mhpq_pkg::ROW_W-1:0]      rd_row,
	input  wire mhpq_pkg::pair_t           child_pair,
	input  wire mhpq_pkg::pair_t           parent_pair,
	output mhpq_pkg::pair_t                rd_pair,
	output mhpq_pkg::rd_req_t              child_req,
	output mhpq_pkg::rd_req_t              parent_req,
	output mhpq_pkg::token_t               down_out,
	output mhpq_pkg::token_t               up_out,
	output mhpq_pkg::entry_t               head,
	output logic                           busy,
	output logic                           done
);

	localparam int LO    = 1 << LEVEL;
	localparam int HI    = (2 * LO - 1 < mhpq_pkg::CAPACITY) ? 2 * LO - 1 : mhpq_pkg::CAPACITY;
	localparam int N_ENT = HI - LO + 1;
	localparam int ROWS  = (N_ENT + 1) / 2;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

	mhpq_pkg::entry_t left_q  [2**RW];
	mhpq_pkg::entry_t right_q [2**RW];
	mhpq_pkg::token_t tok_q;

	logic [mhpq_pkg::IDX_W-1:0] lidx;
	logic                       left_ok;
	logic                       right_ok;
	logic                       take_right;
	logic                       go_down;
	logic                       go_up;
	mhpq_pkg::entry_t           big;
	mhpq_pkg::entry_t           parent;
	mhpq_pkg::entry_t           wr_ent;
	logic [RW-1:0]              wr_row;

	assign rd_pair.left  = left_q[rd_row[RW-1:0]];
	assign rd_pair.right = right_q[rd_row[RW-1:0]];
	assign head          = left_q[0];
	assign busy          = tok_q.valid;

	always_comb begin
		lidx = mhpq_pkg::IDX_W'(2 * LO) + mhpq_pkg::IDX_W'({tok_q.pos, 1'b0});
		left_ok  = lidx <= {1'b0, count};
		right_ok = lidx < {1'b0, count};
		take_right = right_ok &&
			($signed(child_pair.right.prio) > $signed(child_pair.left.prio));
		big = take_right ? child_pair.right : child_pair.left;
		go_down = tok_q.valid && !tok_q.up && left_ok &&
			($signed(big.prio) > $signed(tok_q.ent.prio));
		parent = tok_q.pos[1] ? parent_pair.right : parent_pair.left;
		go_up = (LEVEL > 0) && tok_q.valid && tok_q.up &&
			($signed(parent.prio) < $signed(tok_q.ent.prio));
		if (go_up) begin
			wr_ent = parent;
		end else if (go_down) begin
			wr_ent = big;
		end else begin
			wr_ent = tok_q.ent;
		end
		wr_row = tok_q.pos[RW:1];
		done = tok_q.valid && !go_up && !go_down;
	end

	always_comb begin
		child_req.valid  = tok_q.valid && !tok_q.up;
		child_req.row    = tok_q.pos[mhpq_pkg::ROW_W-1:0];
		parent_req.valid = (LEVEL > 0) && tok_q.valid && tok_q.up;
		parent_req.row   = mhpq_pkg::ROW_W'(tok_q.pos >> 2);

		down_out.valid = go_down;
		down_out.up    = 1'b0;
		down_out.pos   = {tok_q.pos[mhpq_pkg::POS_W-2:0], take_right};
		down_out.ent   = tok_q.ent;

		up_out.valid = go_up;
		up_out.up    = 1'b1;
		up_out.pos   = {1'b0, tok_q.pos[mhpq_pkg::POS_W-1:1]};
		up_out.ent   = tok_q.ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (inj.valid) begin
			tok_q <= inj;
		end else if (down_in.valid) begin
			tok_q <= down_in;
		end else if (up_in.valid) begin
			tok_q <= up_in;
		end else begin
			tok_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_q.valid) begin
			if (tok_q.pos[0]) begin
				right_q[wr_row] <= wr_ent;
			end else begin
				left_q[wr_row] <= wr_ent;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/max_heap_priority_queue_unit.sv
// Top level of the bounded max-heap priority queue: command sequencer, the
// chain of level cells and the result register. Depends on mhpq_pkg,
// mhpq_cell and max_heap_priority_queue_unit_assert.svh.
//
//  Channel  | Direction | tdata (low bit up)                     | tuser
//  ---------+-----------+----------------------------------------+-----------
//  s_axis   | request   | item_priority[15:0], item_tag[31:16]   | command
//  m_axis   | result    | accepted[0], top_priority[16:1],       | top_valid
//           |           | top_tag[32:17], entry_count[39:33],    |
//           |           | is_full[40], zero fill[47:41]          |
//
// A request passes through acceptance, a fetch for a dequeue that leaves
// entries behind, the walk of the sift token over the heap levels (seven
// levels at most) and the registering of the result; a refused request or a
// dequeue that empties the queue skips the fetch and the walk. The token
// walks the chain of level cells one level per clock, and the next request
// can be taken in the cycle after the result is registered.
// Reset clears the sequencer, the count and the cells' tokens; the heap slots
// themselves are not cleared, since only slots below the count are ever read.
// A result that waits on m_axis_tready stalls only the hand-off of the
// following result; the next request is still accepted meanwhile.
`default_nettype none
`include "max_heap_priority_queue_unit_assert.svh"

module max_heap_priority_queue_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,   // item_priority[15:0], item_tag[31:16]
	input  wire  [0:0]  s_axis_tuser,   // command[0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [47:0] m_axis_tdata,   // accepted, top_priority, top_tag, entry_count, is_full
	output logic [0:0]  m_axis_tuser    // top_valid[0]
);

	localparam int LEVELS = mhpq_pkg::LEVELS;

	// Sequencer state.
	mhpq_pkg::state_t               state_q;
	mhpq_pkg::state_t               state_d;
	logic [mhpq_pkg::COUNT_W-1:0]   count_q;
	logic [mhpq_pkg::COUNT_W-1:0]   count_d;
	logic                           ok_q;
	logic                           ok_d;

	// Result register.
	logic                           out_accepted_q;
	logic                           out_top_valid_q;
	logic signed [mhpq_pkg::PRIO_W-1:0] out_prio_q;
	logic [mhpq_pkg::TAG_W-1:0]     out_tag_q;
	logic [mhpq_pkg::COUNT_W-1:0]   out_count_q;
	logic                           out_full_q;
	logic                           out_load;
	logic                           out_free;

	// Slot just past the occupied ones, which is the insert slot for an
	// enqueue and, after the count has dropped, the last slot for a dequeue.
	logic [mhpq_pkg::COUNT_W-1:0]   idx;
	logic [mhpq_pkg::LVL_W-1:0]     idx_lvl;
	logic [mhpq_pkg::POS_W-1:0]     idx_pos;

	logic                           accept;
	logic                           is_push;
	logic                           not_full;
	logic                           done_any;

	logic                           inj_go;
	logic [mhpq_pkg::LVL_W-1:0]     inj_lvl;
	mhpq_pkg::token_t               inj_tok;
	logic                           fetch_go;
	mhpq_pkg::entry_t               fetched;
	mhpq_pkg::entry_t               new_ent;

	// Chain wiring, one element per heap level.
	mhpq_pkg::token_t               inj      [LEVELS];
	mhpq_pkg::token_t               down_out [LEVELS];
	mhpq_pkg::token_t               up_out   [LEVELS];
	mhpq_pkg::token_t               down_in  [LEVELS];
	mhpq_pkg::token_t               up_in    [LEVELS];
	mhpq_pkg::pair_t                rd_pair  [LEVELS];
	mhpq_pkg::pair_t                child_pair  [LEVELS];
	mhpq_pkg::pair_t                parent_pair [LEVELS];
	mhpq_pkg::rd_req_t              child_req   [LEVELS];
	mhpq_pkg::rd_req_t              parent_req  [LEVELS];
	logic [mhpq_pkg::ROW_W-1:0]     rd_row   [LEVELS];
	mhpq_pkg::entry_t               head     [LEVELS];
	logic [LEVELS-1:0]              busy_vec;
	logic [LEVELS-1:0]              done_vec;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign is_push  = mhpq_pkg::cmd_t'(s_axis_tuser[0]) == mhpq_pkg::CMD_PUSH;
	assign not_full = count_q < mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY);
	assign done_any = |done_vec;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = state_q == mhpq_pkg::ST_IDLE;

	assign idx     = count_q + mhpq_pkg::COUNT_W'(1);
	assign idx_lvl = mhpq_pkg::msb_of(idx);
	assign idx_pos = mhpq_pkg::POS_W'(idx - (mhpq_pkg::COUNT_W'(1) << idx_lvl));

	assign new_ent.prio = s_axis_tdata[15:0];
	assign new_ent.tag  = s_axis_tdata[31:16];

	// The last entry is read from its level's row in the fetch cycle.
	assign fetch_go = state_q == mhpq_pkg::ST_FETCH;
	assign fetched  = idx_pos[0] ? rd_pair[idx_lvl].right : rd_pair[idx_lvl].left;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_push) begin
						state_d = not_full ? mhpq_pkg::ST_RUN : mhpq_pkg::ST_FINISH;
					end else if (count_q > mhpq_pkg::COUNT_W'(1)) begin
						state_d = mhpq_pkg::ST_FETCH;
					end else begin
						state_d = mhpq_pkg::ST_FINISH;
					end
				end
			end
			mhpq_pkg::ST_FETCH: begin
				state_d = mhpq_pkg::ST_RUN;
			end
			mhpq_pkg::ST_RUN: begin
				if (done_any) begin
					state_d = mhpq_pkg::ST_FINISH;
				end
			end
			mhpq_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = mhpq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mhpq_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: token injection, count update and result load.
	always_comb begin
		inj_go   = 1'b0;
		inj_lvl  = idx_lvl;
		inj_tok  = '0;
		count_d  = count_q;
		ok_d     = ok_q;
		out_load = 1'b0;
		unique case (state_q)
			mhpq_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_push) begin
						ok_d = not_full;
						if (not_full) begin
							// The new entry starts its climb at the insert slot.
							inj_go        = 1'b1;
							inj_tok.valid = 1'b1;
							inj_tok.up    = 1'b1;
							inj_tok.pos   = idx_pos;
							inj_tok.ent   = new_ent;
							count_d       = count_q + mhpq_pkg::COUNT_W'(1);
						end
					end else begin
						ok_d = count_q != '0;
						if (count_q != '0) begin
							count_d = count_q - mhpq_pkg::COUNT_W'(1);
						end
					end
				end
			end
			mhpq_pkg::ST_FETCH: begin
				// The last entry replaces the root and sinks from there.
				inj_go        = 1'b1;
				inj_lvl       = '0;
				inj_tok.valid = 1'b1;
				inj_tok.up    = 1'b0;
				inj_tok.pos   = '0;
				inj_tok.ent   = fetched;
			end
			mhpq_pkg::ST_RUN: begin
			end
			mhpq_pkg::ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= mhpq_pkg::ST_IDLE;
			count_q       <= '0;
			ok_q          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ok_q    <= ok_d;
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result payload; the root slot is already settled when this loads.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_accepted_q  <= ok_q;
			out_top_valid_q <= count_q != '0;
			out_prio_q      <= (count_q != '0) ? head[0].prio : mhpq_pkg::EMPTY_PRIO;
			out_tag_q       <= (count_q != '0) ? head[0].tag : '0;
			out_count_q     <= count_q;
			out_full_q      <= count_q == mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY);
		end
	end

	assign m_axis_tdata = {7'b0, out_full_q, out_count_q, out_tag_q, out_prio_q,
		out_accepted_q};
	assign m_axis_tuser = out_top_valid_q;

	// The chain of level cells. A token moves down to the child level or up to
	// the parent level each cycle, and each cell reads its neighbors' rows.
	for (genvar l = 0; l < LEVELS; l++) begin : g_level
		assign inj[l] = (inj_go && inj_lvl == mhpq_pkg::LVL_W'(l)) ? inj_tok : '0;

		if (l > 0) begin : g_has_parent
			assign down_in[l]     = down_out[l-1];
			assign parent_pair[l] = rd_pair[l-1];
		end else begin : g_root
			assign down_in[l]     = '0;
			assign parent_pair[l] = '0;
		end

		if (l < LEVELS - 1) begin : g_has_child
			assign up_in[l]      = up_out[l+1];
			assign child_pair[l] = rd_pair[l+1];
		end else begin : g_leaf
			assign up_in[l]      = '0;
			assign child_pair[l] = '0;
		end

		// Only one token exists, so at most one reader wants a level's row.
		always_comb begin
			rd_row[l] = '0;
			if (fetch_go && idx_lvl == mhpq_pkg::LVL_W'(l)) begin
				rd_row[l] = idx_pos[mhpq_pkg::POS_W-1:1];
			end else if (l > 0 && child_req[(l > 0) ? l - 1 : 0].valid) begin
				rd_row[l] = child_req[(l > 0) ? l - 1 : 0].row;
			end else if (l < LEVELS - 1) begin
				rd_row[l] = parent_req[(l < LEVELS - 1) ? l + 1 : l].row;
			end
		end

		mhpq_cell #(
			.LEVEL(l)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.inj         (inj[l]),
			.down_in     (down_in[l]),
			.up_in       (up_in[l]),
			.count       (count_q),
			.rd_row      (rd_row[l]),
			.child_pair  (child_pair[l]),
			.parent_pair (parent_pair[l]),
			.rd_pair     (rd_pair[l]),
			.child_req   (child_req[l]),
			.parent_req  (parent_req[l]),
			.down_out    (down_out[l]),
			.up_out      (up_out[l]),
			.head        (head[l]),
			.busy        (busy_vec[l]),
			.done        (done_vec[l])
		);
	end

	// A sift is a single token; two live tokens would corrupt the heap.
	`MHPQ_ASSERT_ALWAYS(a_single_token, clk, arst_n, $onehot0(busy_vec), "more than one sift token")
	`MHPQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= mhpq_pkg::COUNT_W'(mhpq_pkg::CAPACITY), "count above capacity")
	`MHPQ_ASSERT_IMPLY(a_idle_quiet, clk, arst_n, s_axis_tready, busy_vec == '0, "request taken while a sift is live")
	`MHPQ_ASSERT_IMPLY(a_run_live, clk, arst_n, state_q == mhpq_pkg::ST_RUN, busy_vec != '0, "sift token lost while running")

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for max_heap_priority_queue_unit: drives enqueue and
// dequeue requests and checks every result against a heap kept in the bench.
// Depends on mhpq_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;

	// A watchdog ends the run after this many cycles with no request or result
	// moving. The longest legal quiet stretch is the receiver hold-off below.
	localparam int STALL_LIMIT   = 5000;
	localparam int RX_HOLD_LONG  = 300;
	// Cycles to keep watching after the last result has come back.
	localparam int SETTLE_CYCLES = 20;

	// Fields of one result, unpacked from m_axis_tdata and m_axis_tuser.
	typedef struct packed {
		logic                               accepted;
		logic                               top_valid;
		logic signed [mhpq_pkg::PRIO_W-1:0] top_prio;
		logic [mhpq_pkg::TAG_W-1:0]         top_tag;
		logic [mhpq_pkg::COUNT_W-1:0]       count;
		logic                               full;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	// Heap mirrored in the bench, in heap order from slot 0.
	mhpq_pkg::entry_t mirror_heap [mhpq_pkg::CAPACITY];
	int unsigned      mirror_count;

	outcome_t    pending_outcomes [$];
	int unsigned mismatch_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned rx_hold_left;
	int unsigned quiet_cycles;

	max_heap_priority_queue_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Applies one accepted request to the mirrored heap and returns what the
	// unit must report for it. Sift-up passes only a strictly smaller parent;
	// sift-down swaps only with a strictly larger child and prefers the left
	// child when the two children tie.
	function automatic outcome_t apply_queue_command(input mhpq_pkg::cmd_t cmd,
			input logic signed [mhpq_pkg::PRIO_W-1:0] prio,
			input logic [mhpq_pkg::TAG_W-1:0] tag);
		outcome_t         o;
		int unsigned      node;
		int unsigned      parent;
		int unsigned      left;
		int unsigned      big;
		mhpq_pkg::entry_t held;
		logic             settled;
		o = '0;
		if (cmd == mhpq_pkg::CMD_PUSH) begin
			if (mirror_count < mhpq_pkg::CAPACITY) begin
				node = mirror_count;
				mirror_heap[node].prio = prio;
				mirror_heap[node].tag  = tag;
				mirror_count++;
				settled = 1'b0;
				while (node > 0 && !settled) begin
					parent = (node - 1) / 2;
					if ($signed(mirror_heap[parent].prio) < $signed(mirror_heap[node].prio)) begin
						held                = mirror_heap[parent];
						mirror_heap[parent] = mirror_heap[node];
						mirror_heap[node]   = held;
						node                = parent;
					end else begin
						settled = 1'b1;
					end
				end
				o.accepted = 1'b1;
			end
		end else if (mirror_count > 0) begin
			mirror_count--;
			if (mirror_count > 0) begin
				mirror_heap[0] = mirror_heap[mirror_count];
				node    = 0;
				settled = 1'b0;
				while (!settled) begin
					left = 2 * node + 1;
					if (left >= mirror_count) begin
						settled = 1'b1;
					end else begin
						big = left;
						if (left + 1 < mirror_count) begin
							if ($signed(mirror_heap[left + 1].prio) > $signed(mirror_heap[left].prio)) begin
								big = left + 1;
							end
						end
						if ($signed(mirror_heap[big].prio) > $signed(mirror_heap[node].prio)) begin
							held              = mirror_heap[big];
							mirror_heap[big]  = mirror_heap[node];
							mirror_heap[node] = held;
							node              = big;
						end else begin
							settled = 1'b1;
						end
					end
				end
			end
			o.accepted = 1'b1;
		end
		o.top_valid = (mirror_count > 0);
		o.top_prio  = (mirror_count > 0) ? mirror_heap[0].prio : mhpq_pkg::EMPTY_PRIO;
		o.top_tag   = (mirror_count > 0) ? mirror_heap[0].tag : '0;
		o.count     = mirror_count[mhpq_pkg::COUNT_W-1:0];
		o.full      = (mirror_count == mhpq_pkg::CAPACITY);
		return o;
	endfunction

	// Mostly the full range, with a share of tiny values to force ties and a
	// share of the extremes.
	function automatic logic signed [mhpq_pkg::PRIO_W-1:0] pick_priority();
		logic [mhpq_pkg::PRIO_W-1:0] raw;
		int unsigned                 sel;
		sel = $urandom_range(9, 0);
		if (sel < 6) begin
			raw = mhpq_pkg::PRIO_W'($urandom_range(65535, 0));
		end else if (sel < 8) begin
			raw = mhpq_pkg::PRIO_W'($urandom_range(3, 0));
		end else begin
			case ($urandom_range(3, 0))
				0: raw = 16'h7FFF;
				1: raw = 16'h8000;
				2: raw = 16'hFFFF;
				default: raw = 16'h0000;
			endcase
		end
		return raw;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Offers one request and returns at the falling edge after it is taken.
	// Valid stays high afterwards, so back-to-back requests never lower and
	// raise it within the same time step; an idle cycle lowers it.
	task automatic send_request(input mhpq_pkg::cmd_t cmd,
			input logic signed [mhpq_pkg::PRIO_W-1:0] prio,
			input logic [mhpq_pkg::TAG_W-1:0] tag);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {tag, prio};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		pending_outcomes.push_back(apply_queue_command(cmd, prio, tag));
		@(negedge clk);
	endtask

	// The sender goes quiet until every outstanding result has come back.
	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) begin
			@(negedge clk);
		end
		@(negedge clk);
	endtask

	// Refused dequeue on an empty queue, the priority extremes, a valid entry
	// whose priority equals the empty marker, and draining back past empty.
	task automatic test_empty_and_extremes();
		send_request(mhpq_pkg::CMD_POP, pick_priority(), 16'h1234);
		send_request(mhpq_pkg::CMD_PUSH, 16'sh7FFF, 16'hFFFF);
		send_request(mhpq_pkg::CMD_PUSH, 16'sh8000, 16'h0000);
		send_request(mhpq_pkg::CMD_PUSH, -16'sd1, 16'hA5A5);
		send_request(mhpq_pkg::CMD_PUSH, 16'sd0, 16'h5A5A);
		repeat (5) begin
			send_request(mhpq_pkg::CMD_POP, 16'sh8000, 16'hFFFF);
		end
		wait_all_results();
	endtask

	// Equal priorities: the order in which ties leave checks the strict
	// compares and the left-child preference.
	task automatic test_equal_priorities();
		send_request(mhpq_pkg::CMD_PUSH, 16'sd5, 16'd1);
		send_request(mhpq_pkg::CMD_PUSH, 16'sd5, 16'd2);
		send_request(mhpq_pkg::CMD_PUSH, 16'sd5, 16'd3);
		send_request(mhpq_pkg::CMD_PUSH, 16'sd7, 16'd4);
		send_request(mhpq_pkg::CMD_PUSH, 16'sd5, 16'd5);
		send_request(mhpq_pkg::CMD_PUSH, 16'sd5, 16'd6);
		repeat (6) begin
			send_request(mhpq_pkg::CMD_POP, 16'sd0, 16'd0);
		end
		wait_all_results();
	endtask

	// Fill to capacity, push into the full queue, then drain past empty.
	task automatic test_fill_and_overflow();
		logic [mhpq_pkg::TAG_W-1:0] tag;
		repeat (mhpq_pkg::CAPACITY + 3) begin
			tag = mhpq_pkg::TAG_W'($urandom_range(65535, 0));
			send_request(mhpq_pkg::CMD_PUSH, pick_priority(), tag);
		end
		repeat (mhpq_pkg::CAPACITY + 2) begin
			tag = mhpq_pkg::TAG_W'($urandom_range(65535, 0));
			send_request(mhpq_pkg::CMD_POP, pick_priority(), tag);
		end
		wait_all_results();
	endtask

	// Bursts that lean toward filling, toward draining, or neither, so the
	// count wanders over the whole range and hits both bounds.
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned                sent;
		int unsigned                burst_len;
		int unsigned                push_pct;
		mhpq_pkg::cmd_t             cmd;
		logic [mhpq_pkg::TAG_W-1:0] tag;
		sent = 0;
		while (sent < n_items) begin
			burst_len = $urandom_range(40, 8);
			case ($urandom_range(2, 0))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 20;
			endcase
			repeat (burst_len) begin
				cmd = ($urandom_range(99, 0) < push_pct) ? mhpq_pkg::CMD_PUSH : mhpq_pkg::CMD_POP;
				tag = mhpq_pkg::TAG_W'($urandom_range(65535, 0));
				send_request(cmd, pick_priority(), tag);
				sent++;
			end
		end
		wait_all_results();
	endtask

	// The receiver holds off for a long stretch while requests keep coming,
	// so the unit backs up and stalls its input.
	task automatic test_result_backpressure();
		logic [mhpq_pkg::TAG_W-1:0] tag;
		mhpq_pkg::cmd_t             cmd;
		rx_hold_left = RX_HOLD_LONG;
		repeat (40) begin
			cmd = ($urandom_range(99, 0) < 75) ? mhpq_pkg::CMD_PUSH : mhpq_pkg::CMD_POP;
			tag = mhpq_pkg::TAG_W'($urandom_range(65535, 0));
			send_request(cmd, pick_priority(), tag);
		end
		wait_all_results();
	endtask

	// Result side: tready changes at the falling edge, either held low for a
	// requested stretch or dropped at random.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	// Every result taken is compared field by field with the oldest pending
	// expectation.
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.accepted  = m_axis_tdata[0];
			got.top_prio  = m_axis_tdata[16:1];
			got.top_tag   = m_axis_tdata[32:17];
			got.count     = m_axis_tdata[39:33];
			got.full      = m_axis_tdata[40];
			got.top_valid = m_axis_tuser[0];
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result with nothing pending, entry_count", got.count, 0);
			end else begin
				want = pending_outcomes.pop_front();
				if (got.accepted !== want.accepted)
					report_mismatch("accepted", got.accepted, want.accepted);
				if (got.top_valid !== want.top_valid)
					report_mismatch("top_valid", got.top_valid, want.top_valid);
				if (got.top_prio !== want.top_prio)
					report_mismatch("top_priority", got.top_prio, want.top_prio);
				if (got.top_tag !== want.top_tag)
					report_mismatch("top_tag", got.top_tag, want.top_tag);
				if (got.count !== want.count)
					report_mismatch("entry_count", got.count, want.count);
				if (got.full !== want.full)
					report_mismatch("is_full", got.full, want.full);
			end
		end
	end

	// Watchdog on cycles in which neither a request nor a result moves.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		mirror_count   = 0;
		mismatch_count = 0;
		rx_hold_left   = 0;
		quiet_cycles   = 0;
		send_idle_pct  = 29;
		recv_idle_pct  = 61;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles a little, receiver a lot.
		test_empty_and_extremes();
		test_equal_priorities();
		test_fill_and_overflow();
		test_random_traffic(240);

		// Sender idles a lot, receiver a little.
		send_idle_pct = 61;
		recv_idle_pct = 29;
		test_random_traffic(240);

		// No idling on either side, then the long receiver hold-off.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(240);
		test_result_backpressure();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_cell.sv
rtl/max_heap_priority_queue_unit.sv
tb/tb_top.sv
